// ===== design/dmrh_pkg.sv =====
// Package of the double-modulus rolling hash block.
// Holds widths, primes, reset values, op codes and sequencer states.
// Used by every module of the block; depends on nothing.
package dmrh_pkg;

	localparam int HASH_W      = 30;
	localparam int POS_W       = 13;
	localparam int CHAR_W      = 8;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 3;
	localparam int MAX_LEN_DEF = 4096;

	localparam logic [HASH_W-1:0] PRIME_ONE    = 30'd1000000007;
	localparam logic [HASH_W-1:0] PRIME_TWO    = 30'd1000000009;
	localparam logic [HASH_W-1:0] BASE_ONE_RST = 30'd1007;
	localparam logic [HASH_W-1:0] BASE_TWO_RST = 30'd2009;

	localparam logic [ADDR_W-1:0] REG_BASE_ONE = 3'd0;
	localparam logic [ADDR_W-1:0] REG_BASE_TWO = 3'd4;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_HASH   = 2'd2,
		OP_LCP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_APP_M1,
		ST_APP_W1,
		ST_APP_W2,
		ST_SH_A,
		ST_SH_B,
		ST_SH_C1,
		ST_SH_C2,
		ST_LCP_TEST,
		ST_DONE
	} state_t;

endpackage

// ===== design/double_mod_rolling_hash.sv =====
// Top level of the double-modulus rolling hash block.
// Depends on dmrh_pkg and dmrh_mulmod (one instance per prime).
//
// Input beats on the s_ side carry an op in s_tuser and a byte and two
// positions in s_tdata. Clear and append produce no output beat; hash and
// LCP queries produce one beat on the m_ side. The multipliers are set
// through the APB port at addresses 0 and 4; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each modular product runs in a bit-serial unit, one unit per prime:
//   clear: no product; append: two products per prime;
//   hash query: one product per prime;
//   LCP query: two products per prime for each search probe, with at
//   most 13 probes.
// A query with bad positions goes straight to its error beat.
// s_tready is high only while the block waits for a new beat, which it
// also does while a finished result is held in the output register.
// If the receiver stalls, the block holds the next result until the
// output register frees. Reset empties the string, restores the reset
// multipliers and drops any pending output; the tables need no clearing.
module double_mod_rolling_hash #(
	parameter int MAX_LEN = dmrh_pkg::MAX_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// char_in [7:0], pos_a [20:8], pos_b [33:21], zero above.
	input  logic [39:0]                 s_tdata,
	// op [1:0].
	input  logic [1:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hash_one [29:0], hash_two [59:30], lcp_len [72:60], range_error [73].
	output logic [79:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dmrh_pkg::ADDR_W-1:0] paddr,
	input  logic [dmrh_pkg::DATA_W-1:0] pwdata,
	output logic [dmrh_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import dmrh_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;
	localparam int SW = CW + 1;
	localparam int MW = 2 * HASH_W;

	state_t state_q, state_d;

	logic [HASH_W-1:0] base_one_q, base_two_q;
	logic [HASH_W-1:0] b1, b2;
	logic [LW-1:0]     len_q;
	op_t               op_q;
	logic [CW-1:0]     a_q, b_q;
	logic [LW-1:0]     l_q, r_q;
	logic              side_q;
	logic [SW-1:0]     ok_q, ng_q, mid_q;
	logic [HASH_W-1:0] ha1_q, ha2_q, hr1_q, hr2_q, pn1_q, pn2_q, hn1_q, hn2_q;
	logic [HASH_W-1:0] res1_q, res2_q;
	logic [SW-1:0]     lcp_q;
	logic              err_q;
	logic              m_valid_q;
	logic [79:0]       m_data_q;
	logic [CHAR_W-1:0] s_tdata_ch_q;

	logic [MW-1:0]     hash_mem [0:MAX_LEN];
	logic [MW-1:0]     pow_mem  [0:MAX_LEN];
	logic [MW-1:0]     hash_dout_q, pow_dout_q;
	logic              hash_zero_q, pow_zero_q;
	logic [LW-1:0]     hash_ra, pow_ra;
	logic              mem_we;
	logic [MW-1:0]     hash_rd, pow_rd;

	logic              mul_start;
	logic [HASH_W-1:0] mx1, my1, mx2, my2;
	logic              busy1, busy2;
	logic [HASH_W-1:0] prod1, prod2;

	logic              in_fire;
	op_t               in_op;
	logic [CW-1:0]     in_a, in_b, in_hi;
	logic [HASH_W-1:0] diff1, diff2;
	logic [HASH_W:0]   app1, app2;
	logic [SW-1:0]     mid;
	logic              cfg_we;

	assign in_op = op_t'(s_tuser);
	assign in_a = CW'(s_tdata[20:8]);
	assign in_b = CW'(s_tdata[33:21]);
	assign in_hi = (in_a > in_b) ? in_a : in_b;
	assign in_fire = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	assign b1 = (base_one_q >= PRIME_ONE) ? base_one_q - PRIME_ONE : base_one_q;
	assign b2 = (base_two_q >= PRIME_TWO) ? base_two_q - PRIME_TWO : base_two_q;

	assign hash_rd = hash_zero_q ? '0 : hash_dout_q;
	assign pow_rd = pow_zero_q ? {HASH_W'(1), HASH_W'(1)} : pow_dout_q;

	assign diff1 = (hr1_q >= prod1) ? hr1_q - prod1 : hr1_q + PRIME_ONE - prod1;
	assign diff2 = (hr2_q >= prod2) ? hr2_q - prod2 : hr2_q + PRIME_TWO - prod2;
	assign app1 = (HASH_W + 1)'(prod1) + (HASH_W + 1)'(s_tdata_ch_q);
	assign app2 = (HASH_W + 1)'(prod2) + (HASH_W + 1)'(s_tdata_ch_q);
	assign mid = ok_q + ((ng_q - ok_q) >> 1);

	always_comb begin
		state_d = state_q;
		hash_ra = l_q;
		pow_ra = r_q - l_q;
		mem_we = 1'b0;
		mul_start = 1'b0;
		mx1 = hash_rd[HASH_W-1:0];
		mx2 = hash_rd[MW-1:HASH_W];
		my1 = pow_rd[HASH_W-1:0];
		my2 = pow_rd[MW-1:HASH_W];
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_op)
						OP_CLEAR: state_d = ST_IDLE;
						OP_APPEND: begin
							if (len_q != LW'(MAX_LEN)) begin
								state_d = ST_APP_RD;
							end
						end
						OP_HASH: begin
							if (in_a > in_b || in_b > CW'(len_q)) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_SH_A;
							end
						end
						OP_LCP: begin
							if (in_a > CW'(len_q) || in_b > CW'(len_q)) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_LCP_TEST;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_APP_RD: begin
				hash_ra = len_q;
				pow_ra = len_q;
				state_d = ST_APP_M1;
			end
			ST_APP_M1: begin
				mul_start = 1'b1;
				my1 = b1;
				my2 = b2;
				state_d = ST_APP_W1;
			end
			ST_APP_W1: begin
				mx1 = pn1_q;
				mx2 = pn2_q;
				my1 = b1;
				my2 = b2;
				if (!busy1 && !busy2) begin
					mul_start = 1'b1;
					state_d = ST_APP_W2;
				end
			end
			ST_APP_W2: begin
				if (!busy1 && !busy2) begin
					mem_we = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SH_A: begin
				state_d = ST_SH_B;
			end
			ST_SH_B: begin
				hash_ra = r_q;
				mul_start = 1'b1;
				state_d = ST_SH_C1;
			end
			ST_SH_C1: begin
				state_d = ST_SH_C2;
			end
			ST_SH_C2: begin
				if (!busy1 && !busy2) begin
					if (op_q == OP_HASH) begin
						state_d = ST_DONE;
					end else if (!side_q) begin
						state_d = ST_SH_A;
					end else begin
						state_d = ST_LCP_TEST;
					end
				end
			end
			ST_LCP_TEST: begin
				if (ng_q - ok_q > SW'(1)) begin
					state_d = ST_SH_A;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	dmrh_mulmod #(.PRIME(PRIME_ONE)) u_mul_one (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .x(mx1), .y(my1),
		.busy(busy1), .result(prod1)
	);

	dmrh_mulmod #(.PRIME(PRIME_TWO)) u_mul_two (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .x(mx2), .y(my2),
		.busy(busy2), .result(prod2)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hash_mem[len_q + 1'b1] <= {hn2_q, hn1_q};
			pow_mem[len_q + 1'b1] <= {prod2, prod1};
		end
		hash_dout_q <= hash_mem[hash_ra];
		pow_dout_q <= pow_mem[pow_ra];
	end

	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? DATA_W'(base_two_q) : DATA_W'(base_one_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			base_one_q <= BASE_ONE_RST;
			base_two_q <= BASE_TWO_RST;
			m_valid_q <= 1'b0;
			hash_zero_q <= 1'b1;
			pow_zero_q <= 1'b1;
		end else begin
			state_q <= state_d;
			hash_zero_q <= (hash_ra == '0);
			pow_zero_q <= (pow_ra == '0);
			if (cfg_we) begin
				if (paddr[2] == REG_BASE_TWO[2]) begin
					base_two_q <= pwdata[HASH_W-1:0];
				end else begin
					base_one_q <= pwdata[HASH_W-1:0];
				end
			end
			if (in_fire && in_op == OP_CLEAR) begin
				len_q <= '0;
			end else if (mem_we) begin
				len_q <= len_q + 1'b1;
			end
			if (state_q == ST_DONE && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					op_q <= in_op;
					a_q <= in_a;
					b_q <= in_b;
					s_tdata_ch_q <= s_tdata[7:0];
					l_q <= LW'(in_a);
					r_q <= LW'(in_b);
					res1_q <= '0;
					res2_q <= '0;
					lcp_q <= '0;
					ok_q <= '0;
					ng_q <= SW'(len_q) - SW'(in_hi) + SW'(1);
					err_q <= (in_op == OP_HASH) ? (in_a > in_b || in_b > CW'(len_q))
						: (in_a > CW'(len_q) || in_b > CW'(len_q));
				end
			end
			ST_APP_M1: begin
				pn1_q <= pow_rd[HASH_W-1:0];
				pn2_q <= pow_rd[MW-1:HASH_W];
			end
			ST_APP_W1: begin
				if (!busy1 && !busy2) begin
					hn1_q <= (app1 >= (HASH_W + 1)'(PRIME_ONE))
						? HASH_W'(app1 - (HASH_W + 1)'(PRIME_ONE)) : HASH_W'(app1);
					hn2_q <= (app2 >= (HASH_W + 1)'(PRIME_TWO))
						? HASH_W'(app2 - (HASH_W + 1)'(PRIME_TWO)) : HASH_W'(app2);
				end
			end
			ST_SH_C1: begin
				hr1_q <= hash_rd[HASH_W-1:0];
				hr2_q <= hash_rd[MW-1:HASH_W];
			end
			ST_SH_C2: begin
				if (!busy1 && !busy2) begin
					if (op_q == OP_HASH) begin
						res1_q <= diff1;
						res2_q <= diff2;
					end else if (!side_q) begin
						ha1_q <= diff1;
						ha2_q <= diff2;
						side_q <= 1'b1;
						l_q <= LW'(b_q);
						r_q <= LW'(b_q) + LW'(mid_q);
					end else if (ha1_q == diff1 && ha2_q == diff2) begin
						ok_q <= mid_q;
					end else begin
						ng_q <= mid_q;
					end
				end
			end
			ST_LCP_TEST: begin
				mid_q <= mid;
				side_q <= 1'b0;
				l_q <= LW'(a_q);
				r_q <= LW'(a_q) + LW'(mid);
				lcp_q <= ok_q;
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					m_data_q <= {6'd0, err_q, POS_W'(lcp_q), res2_q, res1_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule

// ===== design/dmrh_mulmod.sv =====
// Bit-serial modular multiplier, one bit of the multiplier per cycle.
// Computes x*y mod PRIME for x, y below PRIME; depends on dmrh_pkg.
module dmrh_mulmod #(
	parameter logic [dmrh_pkg::HASH_W-1:0] PRIME = dmrh_pkg::PRIME_ONE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dmrh_pkg::HASH_W-1:0] x,
	input  logic [dmrh_pkg::HASH_W-1:0] y,
	output logic                        busy,
	output logic [dmrh_pkg::HASH_W-1:0] result
);
	import dmrh_pkg::*;

	localparam int RW = HASH_W + 1;
	localparam int CNT_W = $clog2(HASH_W + 1);

	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] x_q;
	logic [HASH_W-1:0] y_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [RW-1:0]     dbl;
	logic [RW-1:0]     dbl_red;
	logic [RW-1:0]     sum;
	logic [RW-1:0]     sum_red;

	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= RW'(PRIME)) ? dbl - RW'(PRIME) : dbl;
		sum = y_q[HASH_W-1] ? dbl_red + RW'(x_q) : dbl_red;
		sum_red = (sum >= RW'(PRIME)) ? sum - RW'(PRIME) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(HASH_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			acc_q <= sum_red[HASH_W-1:0];
			y_q <= {y_q[HASH_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign result = acc_q;

endmodule

// ===== design/dmrh_checker.sv =====
// Port-level checker for the double-modulus rolling hash block.
// Sees only the top-level ports; bound to double_mod_rolling_hash below.
module dmrh_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);
	import dmrh_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[73] |-> m_tdata[72:0] == '0)
		else $error("error beat carries nonzero fields");

	a_lcp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[72:60] != '0 |-> m_tdata[59:0] == '0)
		else $error("LCP beat carries nonzero hashes");

	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:0] < PRIME_ONE && m_tdata[59:30] < PRIME_TWO)
		else $error("hash not reduced");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("output beat raised right after an input beat was taken");

endmodule

bind double_mod_rolling_hash dmrh_port_checker u_dmrh_port_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
